### src/rsdd_pkg.sv
// ----------------------------------------------------------------------------
// rsdd_pkg
// Shared types and constants for the run-skip-dump frame delta decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package rsdd_pkg;

  // Width of the destination pointer; addresses wrap at 2**FRAME_ADDR_BITS.
  localparam int FRAME_ADDR_BITS = 16;

  localparam int ADDR_W  = 16;
  localparam int LEN_W   = 17;
  localparam int KIND_W  = 2;

  // Result kinds
  localparam logic [KIND_W-1:0] KIND_PIXEL = 2'd0;
  localparam logic [KIND_W-1:0] KIND_FILL  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_END   = 2'd2;

  // Stream codes
  localparam logic [7:0]       OP_RUN     = 8'h00;
  localparam logic [7:0]       OP_LONG    = 8'h80;
  localparam logic [15:0]      WORD_STOP  = 16'h0000;
  localparam logic [LEN_W-1:0] FULL_COUNT = 17'h10000;

  typedef logic [FRAME_ADDR_BITS-1:0] ptr_t;

  typedef enum logic [2:0] {
    PH_STOPPED,
    PH_OPCODE,
    PH_DUMP,
    PH_RUN_COUNT,
    PH_RUN_PIXEL,
    PH_WORD_LO,
    PH_WORD_HI
  } phase_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       frame_start;
  } in_item_t;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [ADDR_W-1:0] address;
    logic [LEN_W-1:0]  length;
    logic [7:0]        value;
  } out_item_t;

  // Decoder step result handed to the output register
  typedef struct packed {
    logic      valid;
    out_item_t item;
  } result_t;

endpackage

`default_nettype wire

### src/rsdd_decode.sv
// ----------------------------------------------------------------------------
// rsdd_decode
// Decode state machine: consumes one stream byte per step, updates the
// destination pointer and counters, and forms at most one write command.
// ----------------------------------------------------------------------------
`default_nettype none

module rsdd_decode (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              step,
  input  wire rsdd_pkg::in_item_t item,
  output rsdd_pkg::result_t      result
);

  rsdd_pkg::phase_t          phase, phase_next;
  rsdd_pkg::ptr_t            ptr, ptr_next;
  logic [rsdd_pkg::LEN_W-1:0] count, count_next;
  logic [7:0]                word_lo, word_lo_next;

  rsdd_pkg::phase_t          phase_eff;
  rsdd_pkg::ptr_t            ptr_eff;
  logic [rsdd_pkg::LEN_W-1:0] count_eff;
  logic [7:0]                b;
  logic [15:0]               word;
  logic [rsdd_pkg::LEN_W-1:0] word_count;

  // Hold state between steps
  always_ff @(posedge clk) begin
    if (rst) begin
      phase   <= rsdd_pkg::PH_STOPPED;
      ptr     <= '0;
      count   <= '0;
      word_lo <= '0;
    end else if (step) begin
      phase   <= phase_next;
      ptr     <= ptr_next;
      count   <= count_next;
      word_lo <= word_lo_next;
    end
  end

  // Decode one byte
  always_comb begin
    b          = item.data_byte;
    word       = {b, word_lo};
    // A zero count in a long op means a full 65536
    word_count = (word[13:0] == 14'd0) ? rsdd_pkg::FULL_COUNT
                                       : {3'b000, word[13:0]};

    // Frame start abandons any open operation
    phase_eff = item.frame_start ? rsdd_pkg::PH_OPCODE : phase;
    ptr_eff   = item.frame_start ? '0 : ptr;
    count_eff = item.frame_start ? '0 : count;

    phase_next   = phase_eff;
    ptr_next     = ptr_eff;
    count_next   = count_eff;
    word_lo_next = word_lo;

    result.valid        = 1'b0;
    result.item.kind    = rsdd_pkg::KIND_PIXEL;
    result.item.address = rsdd_pkg::ADDR_W'(ptr_eff);
    result.item.length  = rsdd_pkg::LEN_W'(1);
    result.item.value   = b;

    case (phase_eff)
      rsdd_pkg::PH_OPCODE: begin
        if (b == rsdd_pkg::OP_RUN) begin
          phase_next = rsdd_pkg::PH_RUN_COUNT;
        end else if (b < rsdd_pkg::OP_LONG) begin
          count_next = {9'd0, b};
          phase_next = rsdd_pkg::PH_DUMP;
        end else if (b == rsdd_pkg::OP_LONG) begin
          phase_next = rsdd_pkg::PH_WORD_LO;
        end else begin
          // short skip
          ptr_next = ptr_eff + rsdd_pkg::FRAME_ADDR_BITS'(b[6:0]);
        end
      end
      rsdd_pkg::PH_DUMP: begin
        result.valid = 1'b1;
        ptr_next     = ptr_eff + rsdd_pkg::FRAME_ADDR_BITS'(1);
        count_next   = count_eff - rsdd_pkg::LEN_W'(1);
        if (count_eff == rsdd_pkg::LEN_W'(1)) begin
          phase_next = rsdd_pkg::PH_OPCODE;
        end
      end
      rsdd_pkg::PH_RUN_COUNT: begin
        count_next = (b == 8'd0) ? rsdd_pkg::FULL_COUNT : {9'd0, b};
        phase_next = rsdd_pkg::PH_RUN_PIXEL;
      end
      rsdd_pkg::PH_RUN_PIXEL: begin
        result.valid       = 1'b1;
        result.item.kind   = rsdd_pkg::KIND_FILL;
        result.item.length = count_eff;
        ptr_next   = ptr_eff + rsdd_pkg::FRAME_ADDR_BITS'(count_eff);
        count_next = '0;
        phase_next = rsdd_pkg::PH_OPCODE;
      end
      rsdd_pkg::PH_WORD_LO: begin
        word_lo_next = b;
        phase_next   = rsdd_pkg::PH_WORD_HI;
      end
      rsdd_pkg::PH_WORD_HI: begin
        if (word == rsdd_pkg::WORD_STOP) begin
          result.valid       = 1'b1;
          result.item.kind   = rsdd_pkg::KIND_END;
          result.item.length = '0;
          result.item.value  = '0;
          phase_next         = rsdd_pkg::PH_STOPPED;
        end else if (!word[15]) begin
          // long skip
          ptr_next   = ptr_eff + rsdd_pkg::FRAME_ADDR_BITS'(word);
          phase_next = rsdd_pkg::PH_OPCODE;
        end else if (!word[14]) begin
          count_next = word_count;
          phase_next = rsdd_pkg::PH_DUMP;
        end else begin
          count_next = word_count;
          phase_next = rsdd_pkg::PH_RUN_PIXEL;
        end
      end
      default: begin
        // stopped: drop the byte
      end
    endcase
  end

endmodule

`default_nettype wire

### src/run_skip_dump_decoder.sv
// ----------------------------------------------------------------------------
// run_skip_dump_decoder
// Run-skip-dump delta frame decoder: one compressed byte in, at most one
// frame-store write command (pixel, fill or frame end) out.
// ----------------------------------------------------------------------------
//   channel   dir  payload              handshake
//   byte      in   rsdd_pkg::in_item_t  byte_valid / byte_stall
//   cmd       out  rsdd_pkg::out_item_t cmd_valid  / cmd_stall
//
// One byte per cycle sustained while cmd is not stalled; a byte taken sits in the
// input register and is decoded from there into the result register, from
// which its command is offered.
// The decode step is a single pass of the state machine per byte.
// Reset (rst, synchronous) leaves the decoder stopped until a frame start.
// A stall on cmd holds the result register and then the input register,
// and byte_stall rises only while the input register is full and blocked.
// ----------------------------------------------------------------------------
`default_nettype none

module run_skip_dump_decoder (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                byte_valid,
  output logic                     byte_stall,
  input  wire rsdd_pkg::in_item_t  byte_item,
  output logic                     cmd_valid,
  input  wire logic                cmd_stall,
  output rsdd_pkg::out_item_t      cmd_item
);

  logic               s1_valid;
  rsdd_pkg::in_item_t s1_item;
  logic               s1_adv;
  rsdd_pkg::result_t  result;

  // Stage 1 moves on when the result register is free or being emptied
  assign s1_adv     = !cmd_valid || !cmd_stall;
  assign byte_stall = s1_valid && !s1_adv;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!byte_stall) begin
      s1_valid <= byte_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!byte_stall && byte_valid) begin
      s1_item <= byte_item;
    end
  end

  rsdd_decode u_decode (
    .clk    (clk),
    .rst    (rst),
    .step   (s1_valid && s1_adv),
    .item   (s1_item),
    .result (result)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      cmd_valid <= 1'b0;
    end else if (s1_adv) begin
      cmd_valid <= s1_valid && result.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && s1_valid && result.valid) begin
      cmd_item <= result.item;
    end
  end

`ifndef SYNTH
  a_kind_legal: assert property (@(posedge clk) disable iff (rst)
    cmd_valid |-> (cmd_item.kind == rsdd_pkg::KIND_PIXEL ||
                   cmd_item.kind == rsdd_pkg::KIND_FILL ||
                   cmd_item.kind == rsdd_pkg::KIND_END))
    else $error("illegal command kind");

  a_pixel_len: assert property (@(posedge clk) disable iff (rst)
    cmd_valid && cmd_item.kind == rsdd_pkg::KIND_PIXEL
      |-> cmd_item.length == rsdd_pkg::LEN_W'(1))
    else $error("pixel write with length other than one");

  a_fill_len: assert property (@(posedge clk) disable iff (rst)
    cmd_valid && cmd_item.kind == rsdd_pkg::KIND_FILL |-> cmd_item.length != '0)
    else $error("fill with zero length");

  a_cmd_source: assert property (@(posedge clk) disable iff (rst)
    $rose(cmd_valid) |-> $past(s1_valid))
    else $error("command without a byte in the input register");
`endif

endmodule

`default_nettype wire

### tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the run-skip-dump delta frame decoder. A directed
// stream walks every opcode, zero counts, address wrap, a frame start in the
// middle of a dump and bytes sent while stopped. Random frames follow:
// mostly well-formed op sequences with random content, plus cut-off ops,
// frames with no stop, and noise. A scoreboard decodes each accepted byte to
// predict the write commands and checks them in order. Both handshakes idle
// at random, and the command side is held off once for a long stretch.
// ----------------------------------------------------------------------------

module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import rsdd_pkg::*;

  localparam logic [15:0] LONG_DUMP_BASE  = 16'h8000;
  localparam logic [15:0] LONG_RUN_BASE   = 16'hC000;
  localparam int          RANDOM_ITEMS    = 490;
  localparam int          HOLD_OFF_CYCLES = 200;
  localparam int          HOLD_OFF_AFTER  = 60;
  localparam int          DRAIN_CYCLES    = 8;
  localparam int          RUN_LIMIT_NS    = 3_000_000;

  // Decode the byte stream ahead of the block and hold the write commands
  // it must produce, oldest first.
  class write_cmd_tracker;
    phase_t           phase;
    ptr_t             ptr;
    logic [LEN_W-1:0] remain;
    logic [7:0]       word_lo;
    out_item_t        pending_cmds[$];
    int               mismatches;
    int               bytes_taken;
    int               cmds_checked;
    int               kind_seen[3];

    function new();
      phase        = PH_STOPPED;
      ptr          = '0;
      remain       = '0;
      word_lo      = '0;
      mismatches   = 0;
      bytes_taken  = 0;
      cmds_checked = 0;
      kind_seen    = '{0, 0, 0};
    endfunction

    // A count of zero stands for the whole 64K span.
    function logic [LEN_W-1:0] span_len(input logic [15:0] n);
      return (n == 16'h0000) ? FULL_COUNT : LEN_W'(n);
    endfunction

    function void queue_cmd(input logic [KIND_W-1:0] kind, input logic [LEN_W-1:0] len,
                            input logic [7:0] val);
      out_item_t cmd;
      cmd.kind    = kind;
      cmd.address = ADDR_W'(ptr);
      cmd.length  = len;
      cmd.value   = val;
      pending_cmds.push_back(cmd);
    endfunction

    function void decode_byte(input in_item_t it);
      logic [7:0]  b;
      logic [15:0] w;
      b = it.data_byte;
      bytes_taken++;
      // frame start drops any unfinished op
      if (it.frame_start) begin
        ptr    = '0;
        remain = '0;
        phase  = PH_OPCODE;
      end
      case (phase)
        PH_OPCODE: begin
          if (b == OP_RUN) begin
            phase = PH_RUN_COUNT;
          end else if (b < OP_LONG) begin
            remain = LEN_W'(b);
            phase  = PH_DUMP;
          end else if (b == OP_LONG) begin
            phase = PH_WORD_LO;
          end else begin
            ptr = ptr + ptr_t'(b[6:0]);
          end
        end
        PH_DUMP: begin
          queue_cmd(KIND_PIXEL, LEN_W'(1), b);
          ptr    = ptr + ptr_t'(1);
          remain = remain - LEN_W'(1);
          if (remain == '0) phase = PH_OPCODE;
        end
        PH_RUN_COUNT: begin
          remain = span_len({8'h00, b});
          phase  = PH_RUN_PIXEL;
        end
        PH_RUN_PIXEL: begin
          queue_cmd(KIND_FILL, remain, b);
          ptr    = ptr + ptr_t'(remain);
          remain = '0;
          phase  = PH_OPCODE;
        end
        PH_WORD_LO: begin
          word_lo = b;
          phase   = PH_WORD_HI;
        end
        PH_WORD_HI: begin
          w = {b, word_lo};
          if (w == WORD_STOP) begin
            queue_cmd(KIND_END, '0, 8'h00);
            phase = PH_STOPPED;
          end else if (w < LONG_DUMP_BASE) begin
            ptr   = ptr + ptr_t'(w);
            phase = PH_OPCODE;
          end else if (w < LONG_RUN_BASE) begin
            remain = span_len(w - LONG_DUMP_BASE);
            phase  = PH_DUMP;
          end else begin
            remain = span_len(w - LONG_RUN_BASE);
            phase  = PH_RUN_PIXEL;
          end
        end
        default: ;  // stopped: drop the byte
      endcase
    endfunction

    function void check_cmd(input out_item_t got);
      out_item_t exp;
      if (pending_cmds.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected command: kind %0d addr %h len %0d value %h",
                   got.kind, got.address, got.length, got.value);
        return;
      end
      exp = pending_cmds.pop_front();
      cmds_checked++;
      kind_seen[exp.kind]++;
      if (got.kind !== exp.kind || got.address !== exp.address ||
          got.length !== exp.length || got.value !== exp.value) begin
        mismatches++;
        if (mismatches <= 10)
          $display({"mismatch: expected kind %0d addr %h len %0d value %h, ",
                    "got kind %0d addr %h len %0d value %h"},
                   exp.kind, exp.address, exp.length, exp.value,
                   got.kind, got.address, got.length, got.value);
      end
    endfunction
  endclass

  logic      clk;
  logic      rst        = 1'b1;
  logic      byte_valid = 1'b0;
  logic      byte_stall;
  in_item_t  byte_item  = '0;
  logic      cmd_valid;
  logic      cmd_stall  = 1'b0;
  out_item_t cmd_item;

  write_cmd_tracker board;
  in_item_t         stim[$];
  int               counted_items = 0;
  bit               fs_next       = 1'b0;

  run_skip_dump_decoder uut (
    .clk        (clk),
    .rst        (rst),
    .byte_valid (byte_valid),
    .byte_stall (byte_stall),
    .byte_item  (byte_item),
    .cmd_valid  (cmd_valid),
    .cmd_stall  (cmd_stall),
    .cmd_item   (cmd_item)
  );

  // Mostly short gaps, now and then a long one.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic void put(input logic [7:0] b);
    stim.push_back(in_item_t'{data_byte: b, frame_start: fs_next});
    fs_next = 1'b0;
    counted_items++;
  endfunction

  // Bytes the decoder drops while stopped.
  function automatic void push_ignored(input logic [7:0] b);
    stim.push_back(in_item_t'{data_byte: b, frame_start: 1'b0});
  endfunction

  function automatic void put_word(input logic [15:0] w);
    put(OP_LONG);
    put(w[7:0]);
    put(w[15:8]);
  endfunction

  // One frame of random ops; cut-off ops and missing stops leave the
  // next frame start to abandon the work in progress.
  function automatic void add_random_frame();
    int          n_ops;
    int          pick;
    int          cnt;
    int          sent;
    bit          cut;
    cut     = 1'b0;
    fs_next = 1'b1;
    n_ops   = $urandom_range(1, 10);
    for (int k = 0; k < n_ops && !cut; k++) begin
      pick = $urandom_range(0, 99);
      if (pick < 25) begin
        // short dump
        cnt = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 127) : $urandom_range(1, 5);
        put(8'(cnt));
        sent = (cnt > 8) ? $urandom_range(1, 6) : cnt;
        repeat (sent) put(8'($urandom));
        cut = (sent != cnt);
      end else if (pick < 40) begin
        // short run, sometimes with the zero count
        put(OP_RUN);
        put(($urandom_range(0, 7) == 0) ? 8'h00 : 8'($urandom));
        put(8'($urandom));
      end else if (pick < 55) begin
        put(8'($urandom_range(int'(OP_LONG) + 1, 255)));
      end else if (pick < 65) begin
        put_word(16'($urandom_range(1, 16'h7FFF)));
      end else if (pick < 77) begin
        // long dump; big or zero counts get cut off
        cnt = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 16'h3FFF) : $urandom_range(1, 4);
        put_word(LONG_DUMP_BASE + 16'(cnt));
        sent = (cnt == 0 || cnt > 8) ? $urandom_range(1, 6) : cnt;
        repeat (sent) put(8'($urandom));
        cut = (sent != cnt);
      end else if (pick < 90) begin
        put_word(($urandom_range(0, 9) == 0) ? LONG_RUN_BASE
                                             : 16'($urandom_range(16'hC000, 16'hFFFF)));
        put(8'($urandom));
      end else begin
        // leave an op unfinished
        put(($urandom_range(0, 1) == 0) ? OP_RUN : OP_LONG);
        if ($urandom_range(0, 1) == 1) put(8'($urandom));
        cut = 1'b1;
      end
    end
    if (!cut && $urandom_range(0, 9) != 0) begin
      put_word(WORD_STOP);
      repeat ($urandom_range(0, 3)) push_ignored(8'($urandom));
    end
    // occasional noise with scattered frame starts
    if ($urandom_range(0, 19) == 0) begin
      repeat ($urandom_range(1, 8)) begin
        stim.push_back(in_item_t'{data_byte: 8'($urandom),
                                  frame_start: ($urandom_range(0, 3) == 0)});
        counted_items++;
      end
    end
  endfunction

  task automatic send_byte(input in_item_t it);
    byte_item  <= it;
    byte_valid <= 1'b1;
    do @(posedge clk); while (byte_stall);
  endtask

  initial begin : clock_gen
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Watch both handshakes; check results before taking the new byte.
  always @(posedge clk) begin
    if (!rst) begin
      if (cmd_valid && !cmd_stall) board.check_cmd(cmd_item);
      if (byte_valid && !byte_stall) board.decode_byte(byte_item);
    end
  end

  // Command side: random stalls, one long hold-off to back up the input.
  initial begin : cmd_receiver
    int open_len;
    int hold_len;
    bit held_off;
    held_off = 1'b0;
    wait (!rst);
    forever begin
      open_len = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 4);
      repeat (open_len) @(posedge clk);
      if (!held_off && board.cmds_checked >= HOLD_OFF_AFTER) begin
        held_off = 1'b1;
        hold_len = HOLD_OFF_CYCLES;
      end else begin
        hold_len = pick_gap();
      end
      if (hold_len > 0) begin
        cmd_stall <= 1'b1;
        repeat (hold_len) @(posedge clk);
        cmd_stall <= 1'b0;
      end
    end
  end

  initial begin : stimulus
    int gap;
    int burst_left;
    int target;
    board = new();

    // stopped after reset: no frame start yet
    push_ignored(OP_RUN);
    // one literal at address 0, with every bit set
    fs_next = 1'b1;
    put(8'h01);
    put(8'hFF);
    // short run with zero count fills the whole store
    put(OP_RUN);
    put(8'h00);
    put(8'hA5);
    // largest short skip
    put(8'hFF);
    // largest long skip
    put_word(16'h7FFF);
    // long run with the largest nonzero count, then the zero-count long run
    put_word(16'hFFFF);
    put(8'h00);
    put_word(LONG_RUN_BASE);
    put(8'h5A);
    // zero-count long dump, abandoned by a frame start after one literal
    put_word(LONG_DUMP_BASE);
    put(8'h80);
    fs_next = 1'b1;
    put_word(WORD_STOP);
    // after stop: dropped
    push_ignored(8'h7F);

    target = counted_items + RANDOM_ITEMS;
    while (counted_items < target) add_random_frame();

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // feed the stream with random gaps and gap-free bursts
    burst_left = 0;
    foreach (stim[i]) begin
      if (burst_left > 0) begin
        burst_left--;
        gap = 0;
      end else begin
        gap = pick_gap();
        if ($urandom_range(0, 19) == 0) burst_left = $urandom_range(10, 40);
      end
      if (gap > 0) begin
        byte_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      send_byte(stim[i]);
    end
    byte_valid <= 1'b0;

    // let the monitor take the last byte, drain, then give stray commands
    // a chance to show up
    @(posedge clk);
    while (board.pending_cmds.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("covered %0d bytes: %0d pixel writes, %0d fills, %0d frame ends",
             board.bytes_taken, board.kind_seen[KIND_PIXEL], board.kind_seen[KIND_FILL],
             board.kind_seen[KIND_END]);
    $display("command side held off %0d cycles once; %0d mismatches",
             HOLD_OFF_CYCLES, board.mismatches);
    if (board.mismatches == 0 && board.pending_cmds.size() == 0) begin
      $display("run_skip_dump_decoder regression: pass");
    end else begin
      $display("run_skip_dump_decoder regression: fail");
    end
    $finish;
  end

  initial begin : watchdog
    #(RUN_LIMIT_NS);
    $display("run_skip_dump_decoder regression: fail");
    $finish;
  end

endmodule

### filelist.f
src/rsdd_pkg.sv
src/rsdd_decode.sv
src/run_skip_dump_decoder.sv
tb/tb_top.sv
